FILE: rtl/qprt_pkg.sv
// Shared types, constants and microcode tables for the quaternion pose block.
`default_nettype none
package qprt_pkg;

    localparam int IN_W  = 152;
    localparam int OUT_W = 264;

    localparam logic [1:0] REG_POS_X = 2'd0;
    localparam logic [1:0] REG_POS_Y = 2'd1;
    localparam logic [1:0] REG_POS_Z = 2'd2;

    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic signed [31:0] SIN_C1  = 32'sd1686629713;
    localparam logic signed [31:0] SIN_C3  = -32'sd693598678;
    localparam logic signed [31:0] SIN_C5  = 32'sd85569306;
    localparam logic signed [31:0] SIN_C7  = -32'sd5026995;
    localparam logic signed [31:0] SIN_C9  = 32'sd172272;
    localparam logic signed [31:0] SIN_C11 = -32'sd3864;
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    localparam logic [4:0] SIN_LAST  = 5'd6;
    localparam logic [4:0] QUAT_LAST = 5'd15;
    localparam logic [4:0] MAT_LAST  = 5'd23;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIN,
        S_QUAT,
        S_MAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic       neg;
        logic       first;
        logic       last;
        logic       dbl;
    } t_term;

    function automatic logic signed [31:0] sin_coef(input logic [4:0] step);
        logic signed [31:0] c;
        case (step)
            5'd1: c = SIN_C9;
            5'd2: c = SIN_C7;
            5'd3: c = SIN_C5;
            5'd4: c = SIN_C3;
            5'd5: c = SIN_C1;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_term mat_term(input logic [4:0] i);
        t_term t;
        case (i)
            5'd0:  t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd1:  t = '{2'd1, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0};
            5'd2:  t = '{2'd2, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0};
            5'd3:  t = '{2'd3, 2'd3, 1'b1, 1'b0, 1'b1, 1'b0};
            5'd4:  t = '{2'd1, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd5:  t = '{2'd0, 2'd3, 1'b1, 1'b0, 1'b1, 1'b1};
            5'd6:  t = '{2'd1, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd7:  t = '{2'd0, 2'd2, 1'b0, 1'b0, 1'b1, 1'b1};
            5'd8:  t = '{2'd1, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd9:  t = '{2'd0, 2'd3, 1'b0, 1'b0, 1'b1, 1'b1};
            5'd10: t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd11: t = '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0};
            5'd12: t = '{2'd2, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0};
            5'd13: t = '{2'd3, 2'd3, 1'b1, 1'b0, 1'b1, 1'b0};
            5'd14: t = '{2'd2, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd15: t = '{2'd0, 2'd1, 1'b1, 1'b0, 1'b1, 1'b1};
            5'd16: t = '{2'd1, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd17: t = '{2'd0, 2'd2, 1'b1, 1'b0, 1'b1, 1'b1};
            5'd18: t = '{2'd2, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd19: t = '{2'd0, 2'd1, 1'b0, 1'b0, 1'b1, 1'b1};
            5'd20: t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0};
            5'd21: t = '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0};
            5'd22: t = '{2'd2, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0};
            5'd23: t = '{2'd3, 2'd3, 1'b0, 1'b0, 1'b1, 1'b0};
            default: t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 1'b0};
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/qprt_mul.sv
// Shared signed multiplier with floor scaling by the fraction width or by Q30.
`default_nettype none
module qprt_mul #(
    parameter int FRAC_BITS = 30
) (
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic               i_sel_q30,
    output logic signed [63:0]      o_p
);
    logic signed [63:0] w_full;

    assign w_full = 64'(i_a) * 64'(i_b);
    assign o_p    = i_sel_q30 ? (w_full >>> 30) : (w_full >>> FRAC_BITS);
endmodule
`default_nettype wire

FILE: rtl/quaternion_pose_rotate_transform.sv
// Quaternion pose rotate block with 3x4 homogeneous transform readout.
// Rotate item: 2x7 sine steps, 16 product steps and 24 matrix steps before the first
// row, all on one shared 32x32 multiplier. Load item: the 24 matrix steps only.
// Rows follow one per output transfer; input ready returns after the third row, so
// no new item is taken before all rows of the current one have been transferred.
// Synchronous active-low reset: quaternion to identity, positions to zero, idle.
`default_nettype none
module quaternion_pose_rotate_transform #(
    parameter int FRAC_BITS  = 30,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // axis[1:0], angle[17:2], load_w[49:18], load_x[81:50], load_y[113:82], load_z[145:114]
    input  wire logic [qprt_pkg::IN_W-1:0]  i_s_axis_tdata,
    // func[0]
    input  wire logic                       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // row[1:0], col_x[33:2], col_y[65:34], col_z[97:66], translation[129:98],
    // quat_w[161:130], quat_x[193:162], quat_y[225:194], quat_z[257:226]
    output logic [qprt_pkg::OUT_W-1:0]      o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [31:0]                i_cfg_data
);
    localparam int ACC_W = 67 - FRAC_BITS;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    qprt_pkg::t_state r_state, n_state;
    logic [4:0]         r_step, n_step;
    logic               r_pass, n_pass;
    logic [1:0]         r_axis, n_axis;
    logic [31:0]        r_ph, n_ph;
    logic signed [31:0] r_q[4], n_q[4];
    logic signed [31:0] r_qb[4], n_qb[4];
    logic signed [31:0] r_rot[4], n_rot[4];
    logic signed [31:0] r_stg[4], n_stg[4];
    logic signed [31:0] r_z, n_z;
    logic signed [31:0] r_poly, n_poly;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [31:0] r_m[9], n_m[9];
    logic [1:0]         r_row, n_row;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_pos[3];

    logic signed [31:0] w_a, w_b;
    logic               w_q30;
    logic signed [63:0] w_prod;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] s;
        if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) begin
            s = v[31:0];
        end else begin
            s = v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

    qprt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_a       (w_a),
        .i_b       (w_b),
        .i_sel_q30 (w_q30),
        .o_p       (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qprt_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_pass   <= 1'b0;
            r_row    <= '0;
            r_q[0]   <= 32'sd1 <<< FRAC_BITS;
            r_qb[0]  <= 32'sd1 <<< FRAC_BITS;
            for (int i = 1; i < 4; i++) begin
                r_q[i]  <= '0;
                r_qb[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_step   <= n_step;
            r_pass   <= n_pass;
            r_row    <= n_row;
            r_q      <= n_q;
            r_qb     <= n_qb;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    qprt_pkg::REG_POS_X: r_pos[0] <= i_cfg_data;
                    qprt_pkg::REG_POS_Y: r_pos[1] <= i_cfg_data;
                    qprt_pkg::REG_POS_Z: r_pos[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_axis <= n_axis;
        r_ph   <= n_ph;
        r_rot  <= n_rot;
        r_stg  <= n_stg;
        r_z    <= n_z;
        r_poly <= n_poly;
        r_acc  <= n_acc;
        r_m    <= n_m;
    end

    always_comb begin
        logic [31:0]        p;
        logic [30:0]        f;
        logic signed [31:0] x;
        logic signed [31:0] s;
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] sum;
        logic signed [31:0] ent;
        logic [1:0]         j;
        logic [1:0]         k;
        logic               qneg;
        qprt_pkg::t_term    mt;

        n_state  = r_state;
        n_step   = r_step;
        n_pass   = r_pass;
        n_axis   = r_axis;
        n_ph     = r_ph;
        n_q      = r_q;
        n_qb     = r_qb;
        n_rot    = r_rot;
        n_stg    = r_stg;
        n_z      = r_z;
        n_poly   = r_poly;
        n_acc    = r_acc;
        n_m      = r_m;
        n_row    = r_row;
        n_ovalid = r_ovalid;

        p = r_pass ? r_ph : r_ph + 32'h4000_0000;
        f = {1'b0, p[29:0]};
        if (p[30]) begin
            f = 31'h4000_0000 - f;
        end
        x    = {1'b0, f};
        j    = r_step[1:0];
        k    = r_step[3:2];
        mt   = qprt_pkg::mat_term(r_step);
        t    = w_prod[ACC_W-1:0];
        sum  = '0;
        ent  = '0;
        s    = '0;
        w_a  = '0;
        w_b  = '0;
        w_q30 = 1'b0;

        case (k)
            2'd0:    qneg = (j != 2'd0);
            2'd1:    qneg = (j == 2'd3);
            2'd2:    qneg = (j == 2'd1);
            default: qneg = (j == 2'd2);
        endcase

        o_s_axis_tready = (r_state == qprt_pkg::S_IDLE);

        case (r_state)
            qprt_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_step = '0;
                    n_acc  = '0;
                    if (i_s_axis_tuser) begin
                        n_q[0]  = i_s_axis_tdata[49:18];
                        n_q[1]  = i_s_axis_tdata[81:50];
                        n_q[2]  = i_s_axis_tdata[113:82];
                        n_q[3]  = i_s_axis_tdata[145:114];
                        n_qb    = n_q;
                        n_state = qprt_pkg::S_MAT;
                    end else begin
                        n_axis  = i_s_axis_tdata[1:0];
                        n_ph    = (32'(i_s_axis_tdata[17:2]) & ANG_MASK) << (31 - ANGLE_BITS);
                        n_pass  = 1'b0;
                        for (int i = 0; i < 4; i++) begin
                            n_rot[i] = '0;
                        end
                        n_state = qprt_pkg::S_SIN;
                    end
                end
            end
            qprt_pkg::S_SIN: begin
                w_q30  = 1'b1;
                n_step = r_step + 5'd1;
                case (r_step)
                    5'd0: begin
                        w_a = x;
                        w_b = x;
                        n_z = w_prod[31:0];
                    end
                    5'd1: begin
                        w_a    = qprt_pkg::SIN_C11;
                        w_b    = r_z;
                        n_poly = w_prod[31:0] + qprt_pkg::sin_coef(r_step);
                    end
                    qprt_pkg::SIN_LAST: begin
                        w_a = r_poly;
                        w_b = x;
                        if (w_prod[63]) begin
                            s = '0;
                        end else if (w_prod > 64'(qprt_pkg::Q30_ONE)) begin
                            s = qprt_pkg::Q30_ONE;
                        end else begin
                            s = w_prod[31:0];
                        end
                        if (p[31]) begin
                            s = -s;
                        end
                        s = s >>> (30 - FRAC_BITS);
                        n_step = '0;
                        if (!r_pass) begin
                            n_rot[0] = s;
                            n_pass   = 1'b1;
                        end else begin
                            if (r_axis != qprt_pkg::AXIS_NONE) begin
                                n_rot[r_axis + 2'd1] = s;
                            end
                            n_state = qprt_pkg::S_QUAT;
                        end
                    end
                    default: begin
                        w_a    = r_poly;
                        w_b    = r_z;
                        n_poly = w_prod[31:0] + qprt_pkg::sin_coef(r_step);
                    end
                endcase
            end
            qprt_pkg::S_QUAT: begin
                w_a    = r_q[j];
                w_b    = r_rot[j ^ k];
                sum    = (j == 2'd0) ? '0 : r_acc;
                sum    = qneg ? sum - t : sum + t;
                n_acc  = sum;
                n_step = r_step + 5'd1;
                if (j == 2'd3) begin
                    for (int i = 0; i < 3; i++) begin
                        n_stg[i] = r_stg[i + 1];
                    end
                    n_stg[3] = sat32(sum);
                end
                if (r_step == qprt_pkg::QUAT_LAST) begin
                    n_q     = n_stg;
                    n_qb    = n_stg;
                    n_step  = '0;
                    n_state = qprt_pkg::S_MAT;
                end
            end
            qprt_pkg::S_MAT: begin
                w_a    = r_q[mt.ia];
                w_b    = r_qb[mt.ib];
                sum    = mt.first ? '0 : r_acc;
                sum    = mt.neg ? sum - t : sum + t;
                n_acc  = sum;
                n_step = r_step + 5'd1;
                if (mt.last) begin
                    ent = sat32(mt.dbl ? (sum <<< 1) : sum);
                    for (int i = 0; i < 8; i++) begin
                        n_m[i] = r_m[i + 1];
                    end
                    n_m[8] = ent;
                end
                if (r_step == qprt_pkg::MAT_LAST) begin
                    n_step   = '0;
                    n_row    = '0;
                    n_ovalid = 1'b1;
                    n_state  = qprt_pkg::S_OUT;
                end
            end
            qprt_pkg::S_OUT: begin
                if (i_m_axis_tready) begin
                    for (int i = 0; i < 6; i++) begin
                        n_m[i] = r_m[i + 3];
                    end
                    n_row = r_row + 2'd1;
                    if (r_row == 2'd2) begin
                        n_ovalid = 1'b0;
                        n_state  = qprt_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state  = qprt_pkg::S_IDLE;
                n_ovalid = 1'b0;
            end
        endcase
    end

    logic signed [31:0] w_trans;

    always_comb begin
        case (r_row)
            2'd0:    w_trans = r_pos[0];
            2'd1:    w_trans = r_pos[1];
            default: w_trans = r_pos[2];
        endcase
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = (r_row == 2'd2);
    assign o_m_axis_tdata  = {6'b0, r_q[3], r_q[2], r_q[1], r_q[0], w_trans,
                              r_m[2], r_m[1], r_m[0], r_row};
endmodule
`default_nettype wire

FILE: rtl/qprt_chk.sv
// Port-level assertion checker for the quaternion pose block, with its bind.
`default_nettype none
module qprt_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_s_axis_tready,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [qprt_pkg::OUT_W-1:0] o_m_axis_tdata,
    input wire logic                      o_m_axis_tlast
);
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while rows pending");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[1:0] == 2'd2)))
        else $error("tlast does not match row two");

    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("rows continue after last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled transfer changed");
endmodule

bind quaternion_pose_rotate_transform qprt_chk u_qprt_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire
